@@ rtl/grid_cell_median_unit_defines.svh @@
// Assertion macros for the grid cell median unit.
`ifndef GRID_CELL_MEDIAN_UNIT_DEFINES_SVH
`define GRID_CELL_MEDIAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GCM_CHECK(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("gcm check failed");
`define GCM_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcm implication failed");
`else
`define GCM_CHECK(lbl, expr)
`define GCM_IMPLIES(lbl, ante, cons)
`endif

`endif

@@ rtl/gcm_pkg.sv @@
// Shared constants and state codes for the grid cell median unit.
package gcm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd4;

    localparam logic [11:0] POS_MAX = 12'hFFF;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

endpackage

@@ rtl/grid_cell_median_unit.sv @@
// Grid cell median unit: per-column histograms in one memory, median walk per cell.
// Usage:
//   Input channel (in_valid/in_ready): one luma pixel per item in raster order,
//   frame_start marks the first pixel of a frame. Output channel
//   (out_valid/out_ready): one item per completed cell with its median, index
//   and a last-cell flag. cfg_we/cfg_index/cfg_data write the five geometry
//   registers; the user must write them only while idle (not enforced here).
//   Each pixel does one histogram memory read, then one write back.
//   A pixel that closes a cell adds a walk over that column's bins
//   (which also zeroes them), then the load of the output register.
//   A frame start with used columns first clears the bins of every used
//   column, skipping unused ones, and then does the pending read.
//   After reset a clearing pass over all MAX_GRID_COLS*256 bins runs (4096
//   with defaults) before in_ready goes high; configuration writes are still taken.
//   The output register holds one result; a new pixel is accepted while it
//   waits, but a following cell result waits after its walk, with in_ready
//   low, until out_ready takes the pending one.
module grid_cell_median_unit #(
    parameter int MAX_GRID_COLS   = 16,
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int COUNT_BITS      = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       pixel,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       median,
    output logic [7:0]                       cell_index,
    output logic                             last_cell,
    input  logic                             cfg_we,
    input  logic [gcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gcm_pkg::*;

    `include "grid_cell_median_unit_defines.svh"

    localparam int XW     = $clog2(MAX_LINE_PIXELS);
    localparam int CW     = (XW + 1 > 13) ? XW + 1 : 13;
    localparam int COLW   = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam int GCW    = ($clog2(MAX_GRID_COLS + 1) > 5) ? $clog2(MAX_GRID_COLS + 1) : 5;
    localparam int IW     = 5 + GCW;
    localparam int ADDR_W = COLW + 8;
    localparam int DEPTH  = MAX_GRID_COLS * 256;
    localparam int TW     = COUNT_BITS + 8;

    // configuration
    logic [12:0] fw_reg, cwid_reg, chgt_reg;
    logic [4:0]  gcols_reg, grows_reg;

    // histogram memory
    logic [COUNT_BITS-1:0] hist_mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic [2:0]            state_reg, state_next;
    logic [7:0]            pix_reg, pix_next;
    logic                  pend_reg, pend_next;
    logic [XW-1:0]         x_reg, x_next, cx_reg, cx_next, col_reg, col_next;
    logic [11:0]           y_reg, y_next, cy_reg, cy_next, row_reg, row_next;
    logic [TW-1:0]         tot_reg [MAX_GRID_COLS];
    logic [TW-1:0]         tot_next [MAX_GRID_COLS];
    logic [MAX_GRID_COLS-1:0] dirty_reg, dirty_next;
    logic [COLW-1:0]       clr_col_reg, clr_col_next;
    logic [7:0]            clr_k_reg, clr_k_next;
    logic                  clr_adv;
    logic [COLW-1:0]       wcol_reg, wcol_next;
    logic [TW-1:0]         walk_tot_reg, walk_tot_next;
    logic [8:0]            k_reg, k_next;
    logic                  dv_reg, dv_next;
    logic [7:0]            didx_reg, didx_next;
    logic [TW-1:0]         acc_reg, acc_next;
    logic                  flo_reg, flo_next, fhi_reg, fhi_next;
    logic [7:0]            lo_v_reg, lo_v_next, hi_v_reg, hi_v_next;
    logic [7:0]            cidx_reg, cidx_next;
    logic                  last_reg, last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            med_reg, med_next;
    logic [7:0]            cell_idx_reg, cell_idx_next;
    logic                  last_cell_reg, last_cell_next;

    // effective geometry
    logic [12:0]   fw_nz, cw_eff, ch_eff;
    logic [CW-1:0] fw_eff;
    logic [GCW-1:0] gc_eff;
    logic [CW-1:0] x_inc, cx_inc;
    logic [12:0]   cy_inc;
    logic          line_wrap, cell_x_end, cell_y_end, in_grid, cell_end, bin_max;
    logic [TW-1:0] cur_tot, acc_sum, lo_rank, hi_rank;
    logic [IW-1:0] idx_full;
    logic          is_last;
    logic [8:0]    med_sum;

    assign fw_nz  = (fw_reg == 13'd0) ? 13'd1 : fw_reg;
    assign fw_eff = (CW'(fw_nz) > CW'(MAX_LINE_PIXELS)) ? CW'(MAX_LINE_PIXELS) : CW'(fw_nz);
    assign cw_eff = (cwid_reg == 13'd0) ? 13'd1 : cwid_reg;
    assign ch_eff = (chgt_reg == 13'd0) ? 13'd1 : chgt_reg;
    assign gc_eff = (GCW'(gcols_reg) > GCW'(MAX_GRID_COLS)) ? GCW'(MAX_GRID_COLS)
                                                            : GCW'(gcols_reg);

    assign x_inc      = CW'(x_reg) + CW'(1);
    assign cx_inc     = CW'(cx_reg) + CW'(1);
    assign cy_inc     = 13'(cy_reg) + 13'd1;
    assign line_wrap  = x_inc >= fw_eff;
    assign cell_x_end = cx_inc == CW'(cw_eff);
    assign cell_y_end = cy_inc == ch_eff;
    assign in_grid    = (CW'(col_reg) < CW'(gc_eff)) && (row_reg < 12'(grows_reg));
    assign cell_end   = in_grid && cell_x_end && cell_y_end;
    assign bin_max    = rdata_reg == {COUNT_BITS{1'b1}};
    assign cur_tot    = tot_reg[col_reg[COLW-1:0]];
    assign idx_full   = IW'(row_reg[4:0]) * IW'(gc_eff) + IW'(col_reg);
    assign is_last    = (row_reg == 12'(grows_reg) - 12'd1)
                     && (CW'(col_reg) == CW'(gc_eff) - CW'(1));
    assign acc_sum    = acc_reg + TW'(rdata_reg);
    assign lo_rank    = (walk_tot_reg - TW'(1)) >> 1;
    assign hi_rank    = walk_tot_reg >> 1;
    assign med_sum    = {1'b0, lo_v_reg} + {1'b0, hi_v_reg};

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign median     = med_reg;
    assign cell_index = cell_idx_reg;
    assign last_cell  = last_cell_reg;

    always_comb
    begin
        state_next     = state_reg;
        pix_next       = pix_reg;
        pend_next      = pend_reg;
        x_next         = x_reg;
        cx_next        = cx_reg;
        col_next       = col_reg;
        y_next         = y_reg;
        cy_next        = cy_reg;
        row_next       = row_reg;
        tot_next       = tot_reg;
        dirty_next     = dirty_reg;
        clr_col_next   = clr_col_reg;
        clr_k_next     = clr_k_reg;
        clr_adv        = 1'b0;
        wcol_next      = wcol_reg;
        walk_tot_next  = walk_tot_reg;
        k_next         = k_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        acc_next       = acc_reg;
        flo_next       = flo_reg;
        fhi_next       = fhi_reg;
        lo_v_next      = lo_v_reg;
        hi_v_next      = hi_v_reg;
        cidx_next      = cidx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        med_next       = med_reg;
        cell_idx_next  = cell_idx_reg;
        last_cell_next = last_cell_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next = pixel;
                    if (frame_start)
                    begin
                        x_next   = '0;
                        cx_next  = '0;
                        col_next = '0;
                        y_next   = '0;
                        cy_next  = '0;
                        row_next = '0;
                    end
                    if (frame_start && (|dirty_reg))
                    begin
                        state_next   = S_CLR;
                        pend_next    = 1'b1;
                        clr_col_next = '0;
                        clr_k_next   = '0;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = {(frame_start ? {COLW{1'b0}} : col_reg[COLW-1:0]), pixel};
                        state_next = S_UPD;
                    end
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {col_reg[COLW-1:0], pix_reg};
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (in_grid)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {col_reg[COLW-1:0], pix_reg};
                    mem_wdata = bin_max ? rdata_reg : rdata_reg + COUNT_BITS'(1);
                    if (!bin_max)
                    begin
                        tot_next[col_reg[COLW-1:0]] = cur_tot + TW'(1);
                    end
                    dirty_next[col_reg[COLW-1:0]] = 1'b1;
                end
                if (cell_end)
                begin
                    wcol_next     = col_reg[COLW-1:0];
                    walk_tot_next = bin_max ? cur_tot : cur_tot + TW'(1);
                    cidx_next     = idx_full[7:0];
                    last_next     = is_last;
                    k_next        = '0;
                    acc_next      = '0;
                    flo_next      = 1'b0;
                    fhi_next      = 1'b0;
                    state_next    = S_WALK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
                // advance the raster position
                if (line_wrap)
                begin
                    x_next   = '0;
                    cx_next  = '0;
                    col_next = '0;
                    if (y_reg < POS_MAX)
                    begin
                        y_next = y_reg + 12'd1;
                        if (cell_y_end)
                        begin
                            cy_next  = '0;
                            row_next = row_reg + 12'd1;
                        end
                        else
                        begin
                            cy_next = cy_inc[11:0];
                        end
                    end
                end
                else
                begin
                    x_next = x_inc[XW-1:0];
                    if (cell_x_end)
                    begin
                        cx_next  = '0;
                        col_next = col_reg + XW'(1);
                    end
                    else
                    begin
                        cx_next = cx_inc[XW-1:0];
                    end
                end
            end
            S_CLR:
            begin
                if (dirty_reg[clr_col_reg])
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = {clr_col_reg, clr_k_reg};
                    clr_k_next = clr_k_reg + 8'd1;
                    if (clr_k_reg == 8'hFF)
                    begin
                        dirty_next[clr_col_reg] = 1'b0;
                        tot_next[clr_col_reg]   = '0;
                        clr_adv                 = 1'b1;
                    end
                end
                else
                begin
                    clr_adv = 1'b1;
                end
                if (clr_adv)
                begin
                    if (clr_col_reg == COLW'(MAX_GRID_COLS - 1))
                    begin
                        state_next = pend_reg ? S_RD : S_IDLE;
                        pend_next  = 1'b0;
                    end
                    else
                    begin
                        clr_col_next = clr_col_reg + COLW'(1);
                    end
                end
            end
            S_WALK:
            begin
                if (!k_reg[8])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {wcol_reg, k_reg[7:0]};
                    k_next    = k_reg + 9'd1;
                    dv_next   = 1'b1;
                    didx_next = k_reg[7:0];
                end
                if (dv_reg)
                begin
                    acc_next = acc_sum;
                    if (!flo_reg && (acc_sum > lo_rank))
                    begin
                        flo_next  = 1'b1;
                        lo_v_next = didx_reg;
                    end
                    if (!fhi_reg && (acc_sum > hi_rank))
                    begin
                        fhi_next  = 1'b1;
                        hi_v_next = didx_reg;
                    end
                    // zero each bin behind the read
                    mem_we    = 1'b1;
                    mem_waddr = {wcol_reg, didx_reg};
                    if (didx_reg == 8'hFF)
                    begin
                        tot_next[wcol_reg]   = '0;
                        dirty_next[wcol_reg] = 1'b0;
                        state_next           = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    med_next       = med_sum[8:1];
                    cell_idx_next  = cidx_reg;
                    last_cell_next = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= hist_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= 13'd640;
            cwid_reg  <= 13'd64;
            chgt_reg  <= 13'd64;
            gcols_reg <= 5'd3;
            grows_reg <= 5'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH: fw_reg    <= cfg_data;
                CFG_CELL_WIDTH:  cwid_reg  <= cfg_data;
                CFG_CELL_HEIGHT: chgt_reg  <= cfg_data;
                CFG_GRID_COLS:   gcols_reg <= cfg_data[4:0];
                CFG_GRID_ROWS:   grows_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            pend_reg      <= 1'b0;
            x_reg         <= '0;
            cx_reg        <= '0;
            col_reg       <= '0;
            y_reg         <= '0;
            cy_reg        <= '0;
            row_reg       <= '0;
            for (int i = 0; i < MAX_GRID_COLS; i++)
            begin
                tot_reg[i] <= '0;
            end
            dirty_reg     <= '1;
            clr_col_reg   <= '0;
            clr_k_reg     <= '0;
            k_reg         <= '0;
            dv_reg        <= 1'b0;
            flo_reg       <= 1'b0;
            fhi_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            x_reg         <= x_next;
            cx_reg        <= cx_next;
            col_reg       <= col_next;
            y_reg         <= y_next;
            cy_reg        <= cy_next;
            row_reg       <= row_next;
            tot_reg       <= tot_next;
            dirty_reg     <= dirty_next;
            clr_col_reg   <= clr_col_next;
            clr_k_reg     <= clr_k_next;
            k_reg         <= k_next;
            dv_reg        <= dv_next;
            flo_reg       <= flo_next;
            fhi_reg       <= fhi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        wcol_reg     <= wcol_next;
        walk_tot_reg <= walk_tot_next;
        didx_reg     <= didx_next;
        acc_reg      <= acc_next;
        lo_v_reg     <= lo_v_next;
        hi_v_reg     <= hi_v_next;
        cidx_reg     <= cidx_next;
        last_reg     <= last_next;
        med_reg      <= med_next;
        cell_idx_reg <= cell_idx_next;
        last_cell_reg <= last_cell_next;
    end

    // a result only appears after a completed walk
    `GCM_IMPLIES(a_out_from_walk, $rose(out_valid_reg), $past(state_reg == S_DONE))
    // both ranks must have been located by the end of the walk
    `GCM_IMPLIES(a_ranks_found, state_reg == S_DONE, flo_reg && fhi_reg)
    // the lower middle value never exceeds the upper one
    `GCM_IMPLIES(a_rank_order, state_reg == S_DONE, lo_v_reg <= hi_v_reg)

endmodule

@@ tb/grid_cell_median_unit_tb.sv @@
// Self-checking testbench for the grid cell median unit: directed and random geometry, raster frames.
module grid_cell_median_unit_tb;
    import gcm_pkg::*;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } luma_item_t;

    typedef struct packed {
        logic [7:0] median;
        logic [7:0] cell_index;
        logic       last_cell;
    } cell_result_t;

    localparam int NCOLS     = 16;
    localparam int LINE_MAX  = 4096;
    localparam int BIN_LIMIT = (1 << 24) - 1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] pixel;
    logic frame_start;
    logic out_valid;
    logic out_ready;
    logic [7:0] median;
    logic [7:0] cell_index;
    logic last_cell;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    grid_cell_median_unit DUT (.*);

    luma_item_t   pixel_queue[$];
    cell_result_t cell_medians[$];

    // shadow geometry and histograms
    int hist[NCOLS][256];
    int line_w, cell_w, cell_h, cols_cfg, rows_cfg;
    int x_pos, y_pos;

    int  errors;
    int  hold_left;
    int  n_results;
    int  n_sent;
    int  n_phases;
    bit  calm;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int rank_value(input int col, input longint rank);
        longint acc;
        acc = 0;
        for (int v = 0; v < 256; v++)
        begin
            acc += hist[col][v];
            if (acc > rank)
                return v;
        end
        return 255;
    endfunction

    function automatic void cell_median_step(input logic [7:0] px, input logic fs);
        int cw, ch, gc, fw, col, row, lo, hi;
        longint total;
        cell_result_t r;
        cw = (cell_w == 0) ? 1 : cell_w;
        ch = (cell_h == 0) ? 1 : cell_h;
        gc = (cols_cfg > NCOLS) ? NCOLS : cols_cfg;
        fw = (line_w == 0) ? 1 : line_w;
        if (fw > LINE_MAX)
            fw = LINE_MAX;
        if (fs)
        begin
            x_pos = 0;
            y_pos = 0;
            foreach (hist[c, v])
                hist[c][v] = 0;
        end
        col = x_pos / cw;
        row = y_pos / ch;
        if (col < gc && row < rows_cfg)
        begin
            if (hist[col][px] < BIN_LIMIT)
                hist[col][px]++;
            if (x_pos % cw == cw - 1 && y_pos % ch == ch - 1)
            begin
                total = 0;
                for (int v = 0; v < 256; v++)
                    total += hist[col][v];
                lo = rank_value(col, (total - 1) / 2);
                hi = rank_value(col, total / 2);
                r.median = (total == 0) ? 8'd0 : 8'((lo + hi) / 2);
                r.cell_index = 8'(row * gc + col);
                r.last_cell = (row == rows_cfg - 1 && col == gc - 1);
                cell_medians.push_back(r);
                for (int v = 0; v < 256; v++)
                    hist[col][v] = 0;
            end
        end
        if (x_pos + 1 >= fw)
        begin
            x_pos = 0;
            if (y_pos < 4095)
                y_pos++;
        end
        else
            x_pos = x_pos + 1;
    endfunction

    // driver: takes items from pixel_queue; predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            luma_item_t it;
            if (in_valid && in_ready)
                cell_median_step(pixel, frame_start);
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 21))
                begin
                    it = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    pixel <= it.pixel;
                    frame_start <= it.frame_start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            cell_result_t e;
            if (cell_medians.size() == 0)
            begin
                $error("unexpected result: median %0d cell_index %0d last_cell %0d",
                       median, cell_index, last_cell);
                errors++;
            end
            else
            begin
                e = cell_medians.pop_front();
                n_results++;
                if (median !== e.median)
                begin
                    $error("median: expected %0d, got %0d", e.median, median);
                    errors++;
                end
                if (cell_index !== e.cell_index)
                begin
                    $error("cell_index: expected %0d, got %0d", e.cell_index, cell_index);
                    errors++;
                end
                if (last_cell !== e.last_cell)
                begin
                    $error("last_cell: expected %0d, got %0d", e.last_cell, last_cell);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || cell_medians.size() != 0 || in_valid)
            @(posedge clk);
        // a trailing pixel may still be walking or clearing histograms
        repeat (4500) @(posedge clk);
    endtask

    task automatic set_geometry(input int fw, input int cw, input int ch,
                                input int gc, input int gr);
        int vals[5];
        vals = '{fw, cw, ch, gc, gr};
        wait_idle();
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= CFG_DATA_W'(vals[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        line_w = fw & 13'h1FFF;
        cell_w = cw & 13'h1FFF;
        cell_h = ch & 13'h1FFF;
        cols_cfg = gc & 5'h1F;
        rows_cfg = gr & 5'h1F;
        n_phases++;
    endtask

    task automatic push_pixel(input int px, input bit fs);
        luma_item_t it;
        it.pixel = 8'(px);
        it.frame_start = fs;
        pixel_queue.push_back(it);
        n_sent++;
    endtask

    // one frame of n pixels; style 0 random, 1 narrow range, 2 extremes only
    task automatic push_frame(input int n, input int style, input bit noisy);
        int base;
        base = $urandom_range(255);
        for (int i = 0; i < n; i++)
        begin
            int px;
            case (style)
                0: px = $urandom_range(255);
                1: px = (base + $urandom_range(3)) & 255;
                default: px = $urandom_range(1) ? 255 : 0;
            endcase
            push_pixel(px, i == 0 || (noisy && $urandom_range(99) == 0));
        end
    endtask

    initial
    begin
        int fw, cw, ch, gc, gr, fwe, n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_left = 0;
        errors = 0;
        n_results = 0;
        n_sent = 0;
        n_phases = 0;
        calm = 1'b0;
        line_w = 640; cell_w = 64; cell_h = 64; cols_cfg = 3; rows_cfg = 3;
        x_pos = 0;
        y_pos = 0;
        foreach (hist[c, v])
            hist[c][v] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 2x2 cells, even counts, extreme values, dropped partial cell
        set_geometry(4, 2, 2, 2, 2);
        push_pixel(0, 1); push_pixel(255, 0); push_pixel(7, 0); push_pixel(9, 0);
        push_pixel(255, 0); push_pixel(254, 0); push_pixel(3, 0); push_pixel(3, 0);
        push_pixel(200, 1); push_pixel(100, 0); push_pixel(50, 0);
        push_pixel(128, 1);
        for (int i = 1; i < 16; i++)
            push_pixel(i * 17, 0);
        // odd count, zero cell sizes, zero width, oversize column count
        set_geometry(3, 3, 1, 1, 2);
        push_frame(6, 0, 0);
        set_geometry(0, 0, 0, 31, 3);
        push_frame(4, 0, 0);
        // empty grids
        set_geometry(4, 1, 1, 0, 2);
        push_frame(8, 0, 0);
        set_geometry(4, 1, 1, 2, 0);
        push_frame(8, 0, 0);
        // index wraps past 8 bits: 16 columns, 17 rows of 1x1 cells;
        // the receiver holds off long enough for the block to back up
        set_geometry(16, 1, 1, 16, 17);
        hold_left <= 3000;
        push_frame(16 * 17, 2, 0);
        // widest stride: clamped to the line limit
        set_geometry(8191, 1, 1, 2, 2);
        push_frame(40, 2, 0);
        // huge cells never complete
        set_geometry(5, 8191, 8191, 1, 1);
        push_frame(12, 0, 0);

        // random geometry
        while (n_sent < 1700)
        begin
            fw = $urandom_range(1, 12);
            cw = $urandom_range(1, 4);
            ch = $urandom_range(1, 3);
            gc = $urandom_range(1, 5);
            gr = $urandom_range(1, 4);
            case ($urandom_range(9))
                0: cw = 0;
                1: ch = 0;
                2: gc = $urandom_range(17, 31);
                3: fw = 0;
                default: ;
            endcase
            set_geometry(fw, cw, ch, gc, gr);
            calm = (n_phases % 6 == 3);
            fwe = (fw == 0) ? 1 : fw;
            n = fwe * (gr * ((ch == 0) ? 1 : ch) + 1);
            for (int f = 0; f < $urandom_range(1, 3); f++)
            begin
                push_frame(n, $urandom_range(9) < 7 ? 0 : $urandom_range(1, 2),
                           $urandom_range(3) == 0);
            end
        end

        wait_idle();
        $display("%0d geometry phases, %0d pixels sent, %0d cell medians checked",
                 n_phases, n_sent, n_results);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
